// ===== rtl/fbcd_pkg.sv =====
// Package for the FIFO block cache directory: sizes, codes, word and port types.
// Used by fbcd_ctrl and the top level in rtl/.
`timescale 1ns / 1ps

package fbcd_pkg;

   localparam int ENTRIES   = 1024;
   localparam int IDX_W     = $clog2(ENTRIES);
   localparam int N_W       = IDX_W + 1;
   localparam int SIZE_W    = 11;
   localparam int DEV_W     = 16;
   localparam int BLK_W     = 32;
   localparam int SLOT_W    = 10;
   localparam int COUNT_W   = 11;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 16;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
   localparam logic [DEV_W-1:0]   NO_DEVICE = '0;
   localparam logic [DEV_W-1:0]   RAM_DEVICE_RESET = 16'd256;

   typedef enum logic [1:0] {
      OP_LOOKUP = 2'd0,
      OP_INSERT = 2'd1,
      OP_INVAL  = 2'd2
   } op_type;

   localparam logic [CSR_IDX_W-1:0] CSR_CACHE_SIZE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_RAM_DEVICE = 1'b1;

   typedef struct packed {
      logic [1:0]       op;
      logic [DEV_W-1:0] device;
      logic [BLK_W-1:0] block_number;
      logic             search_only;
   } req_type;

   typedef struct packed {
      logic              hit;
      logic [SLOT_W-1:0] slot;
   } rsp_type;

   typedef struct packed {
      logic [SIZE_W-1:0] cache_size;
      logic [DEV_W-1:0]  ram_device;
   } cfg_type;

   typedef struct packed {
      logic [DEV_W-1:0] device;
      logic [BLK_W-1:0] block;
   } tag_type;

   localparam int TAG_W = $bits(tag_type);

   typedef struct packed {
      logic             we;
      logic [IDX_W-1:0] waddr;
      tag_type          wdata;
      logic [IDX_W-1:0] raddr;
   } tag_port_type;

   typedef struct packed {
      logic               we;
      logic [IDX_W-1:0]   waddr;
      logic [COUNT_W-1:0] wdata;
      logic [IDX_W-1:0]   raddr;
   } cnt_port_type;

endpackage

// ===== rtl/fbcd_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// Standalone; no package dependency.
`timescale 1ns / 1ps

module fbcd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/fbcd_ctrl.sv =====
// Directory sequencer: clear pass, lookup search, insert and invalidate walks
// over the tag and count RAMs. Uses fbcd_pkg.
`timescale 1ns / 1ps

module fbcd_ctrl
   import fbcd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  req_type            req_word,
   input  cfg_type            cfg,
   output tag_port_type       tag_port,
   input  tag_type            tag_rd,
   output cnt_port_type       cnt_port,
   input  logic [COUNT_W-1:0] cnt_rd,
   output logic               rsp_strobe,
   output rsp_type            rsp_word
);

   typedef enum logic [9:0] {
      ST_CLR       = 10'b0000000001,
      ST_IDLE      = 10'b0000000010,
      ST_LK_CHK    = 10'b0000000100,
      ST_LK_SRCH   = 10'b0000001000,
      ST_INS_TAG   = 10'b0000010000,
      ST_INS_DEC   = 10'b0000100000,
      ST_INS_RDINC = 10'b0001000000,
      ST_INS_INC   = 10'b0010000000,
      ST_INV_CMP   = 10'b0100000000,
      ST_INV_DEC   = 10'b1000000000
   } state_type;

   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   cur_ff, cur_in;
   logic [N_W-1:0]     issued_ff, issued_in;
   logic [N_W-1:0]     n_ff, n_in;
   logic [IDX_W-1:0]   next_ff, next_in;
   logic [IDX_W-1:0]   bkt_ff, bkt_in;
   logic               dis_ff, dis_in;
   req_type            item_ff, item_in;
   logic               rsp_strobe_ff;
   rsp_type            rsp_word_ff;

   logic               fin, fin_hit;
   logic [IDX_W-1:0]   fin_slot;
   logic               dis_acc;
   logic [N_W-1:0]     n_lim, n_acc;
   logic [IDX_W-1:0]   start_slot, prev_slot, cur_inc;
   logic               last_slot;
   logic [IDX_W-1:0]   item_bkt, tag_bkt;
   logic [COUNT_W-1:0] cnt_dec, cnt_inc;

   always_comb begin
      // slots in use, with a RAM-device lookup disabling right away
      dis_acc = dis_ff | ((req_word.op == OP_LOOKUP) &&
                          (req_word.device == cfg.ram_device));
      n_lim = (cfg.cache_size > SIZE_W'(ENTRIES)) ? N_W'(ENTRIES) : N_W'(cfg.cache_size);
      n_acc = dis_acc ? '0 : n_lim;
      start_slot = ({1'b0, next_ff} < n_acc) ? next_ff : '0;
      prev_slot  = IDX_W'(((cur_ff == '0) ? n_ff : {1'b0, cur_ff}) - 1'b1);
      cur_inc    = cur_ff + 1'b1;
      last_slot  = ({1'b0, cur_ff} + 1'b1) == n_ff;
      item_bkt   = item_ff.block_number[IDX_W-1:0];
      tag_bkt    = tag_rd.block[IDX_W-1:0];
      cnt_dec    = (cnt_rd == '0) ? '0 : cnt_rd - 1'b1;
      cnt_inc    = (cnt_rd == COUNT_MAX) ? cnt_rd : cnt_rd + 1'b1;
   end

   always_comb begin
      state_in  = state_ff;
      cur_in    = cur_ff;
      issued_in = issued_ff;
      n_in      = n_ff;
      next_in   = next_ff;
      bkt_in    = bkt_ff;
      dis_in    = dis_ff;
      item_in   = item_ff;
      fin       = 1'b0;
      fin_hit   = 1'b0;
      fin_slot  = '0;
      tag_port.we    = 1'b0;
      tag_port.waddr = cur_ff;
      tag_port.wdata = '0;
      tag_port.raddr = cur_ff;
      cnt_port.we    = 1'b0;
      cnt_port.waddr = bkt_ff;
      cnt_port.wdata = '0;
      cnt_port.raddr = bkt_ff;

      case (state_ff)
         ST_CLR: begin
            tag_port.we    = 1'b1;
            cnt_port.we    = 1'b1;
            cnt_port.waddr = cur_ff;
            cur_in         = cur_inc;
            if (cur_ff == IDX_W'(ENTRIES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               item_in = req_word;
               dis_in  = dis_acc;
               n_in    = n_acc;
               cur_in  = start_slot;
               case (req_word.op)
                  OP_LOOKUP: begin
                     if (n_acc == '0 || req_word.search_only) begin
                        fin = 1'b1;
                     end else begin
                        cnt_port.raddr = req_word.block_number[IDX_W-1:0];
                        state_in = ST_LK_CHK;
                     end
                  end
                  OP_INSERT: begin
                     if (n_acc == '0) begin
                        fin = 1'b1;
                     end else begin
                        tag_port.raddr = start_slot;
                        next_in  = (({1'b0, start_slot} + 1'b1) >= n_acc) ? '0
                                                                          : start_slot + 1'b1;
                        state_in = ST_INS_TAG;
                     end
                  end
                  OP_INVAL: begin
                     if (n_acc == '0) begin
                        fin = 1'b1;
                     end else begin
                        tag_port.raddr = '0;
                        cur_in   = '0;
                        state_in = ST_INV_CMP;
                     end
                  end
                  default: begin
                     fin = 1'b1;
                  end
               endcase
            end
         end
         ST_LK_CHK: begin
            // bucket filter says no match possible
            if (cnt_rd == '0) begin
               fin = 1'b1;
            end else begin
               tag_port.raddr = prev_slot;
               cur_in    = prev_slot;
               issued_in = N_W'(1);
               state_in  = ST_LK_SRCH;
            end
         end
         ST_LK_SRCH: begin
            // tag_rd holds the slot at cur_ff; search runs newest first
            if (tag_rd.device == item_ff.device && tag_rd.block == item_ff.block_number) begin
               fin      = 1'b1;
               fin_hit  = 1'b1;
               fin_slot = cur_ff;
            end else if (issued_ff == n_ff) begin
               fin = 1'b1;
            end else begin
               tag_port.raddr = prev_slot;
               cur_in    = prev_slot;
               issued_in = issued_ff + 1'b1;
            end
         end
         ST_INS_TAG: begin
            tag_port.we    = 1'b1;
            tag_port.wdata = '{device: item_ff.device, block: item_ff.block_number};
            if (tag_rd.device != NO_DEVICE) begin
               cnt_port.raddr = tag_bkt;
               bkt_in   = tag_bkt;
               state_in = ST_INS_DEC;
            end else begin
               cnt_port.raddr = item_bkt;
               bkt_in   = item_bkt;
               state_in = ST_INS_INC;
            end
         end
         ST_INS_DEC: begin
            cnt_port.we    = 1'b1;
            cnt_port.wdata = cnt_dec;
            state_in       = ST_INS_RDINC;
         end
         ST_INS_RDINC: begin
            // separate read so a shared bucket sees the decremented count
            cnt_port.raddr = item_bkt;
            bkt_in   = item_bkt;
            state_in = ST_INS_INC;
         end
         ST_INS_INC: begin
            cnt_port.we    = 1'b1;
            cnt_port.wdata = cnt_inc;
            fin      = 1'b1;
            fin_slot = cur_ff;
         end
         ST_INV_CMP: begin
            if (tag_rd.device == item_ff.device) begin
               tag_port.we    = 1'b1;
               tag_port.wdata = '{device: NO_DEVICE, block: tag_rd.block};
               cnt_port.raddr = tag_bkt;
               bkt_in   = tag_bkt;
               state_in = ST_INV_DEC;
            end else if (last_slot) begin
               fin = 1'b1;
            end else begin
               tag_port.raddr = cur_inc;
               cur_in = cur_inc;
            end
         end
         ST_INV_DEC: begin
            cnt_port.we    = 1'b1;
            cnt_port.wdata = cnt_dec;
            if (last_slot) begin
               fin = 1'b1;
            end else begin
               tag_port.raddr = cur_inc;
               cur_in   = cur_inc;
               state_in = ST_INV_CMP;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (fin) begin
         state_in = ST_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLR;
         cur_ff        <= '0;
         issued_ff     <= '0;
         n_ff          <= '0;
         next_ff       <= '0;
         bkt_ff        <= '0;
         dis_ff        <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cur_ff        <= cur_in;
         issued_ff     <= issued_in;
         n_ff          <= n_in;
         next_ff       <= next_in;
         bkt_ff        <= bkt_in;
         dis_ff        <= dis_in;
         rsp_strobe_ff <= fin;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      if (fin) begin
         rsp_word_ff.hit  <= fin_hit;
         rsp_word_ff.slot <= SLOT_W'(fin_slot);
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_word_ff;

endmodule

// ===== rtl/fifo_block_cache_directory_top.sv =====
// FIFO block cache directory, top level: CSRs, tag and count RAMs, sequencer.
// Reset: synchronous; then a clearing pass over 1024 entries (busy high), CSRs usable at once.
// Result strobe is registered, in the cycle after the walk ends; no backpressure on results.
// Lookup: miss-by-rule answered from idle, else bucket count read, slots compared if nonzero.
// Insert: tag written, then evicted tag's bucket counted down if any, then new bucket counted up.
// Invalidate: each live slot compared, freed ones counted down; next word taken in strobe cycle.
`timescale 1ns / 1ps

module fifo_block_cache_directory_top
   import fbcd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // request word
   input  logic                 start,
   output logic                 busy,
   input  req_type              req_word,
   // result word
   output logic                 rsp_strobe,
   output rsp_type              rsp_word,
   // CSR write port
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata
);

   cfg_type            cfg_ff;
   tag_port_type       tag_port;
   cnt_port_type       cnt_port;
   tag_type            tag_rd;
   logic [TAG_W-1:0]   tag_rd_raw;
   logic [COUNT_W-1:0] cnt_rd;

   // CSRs; cache_size keeps its low 11 bits
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cache_size <= '0;
         cfg_ff.ram_device <= RAM_DEVICE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CACHE_SIZE: cfg_ff.cache_size <= csr_wdata[SIZE_W-1:0];
            CSR_RAM_DEVICE: cfg_ff.ram_device <= csr_wdata[DEV_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // tags: device and block number per slot
   fbcd_ram #(
      .WIDTH (TAG_W),
      .DEPTH (ENTRIES)
   ) u_tag_ram (
      .clock (clock),
      .we    (tag_port.we),
      .waddr (tag_port.waddr),
      .wdata (tag_port.wdata),
      .raddr (tag_port.raddr),
      .rdata (tag_rd_raw)
   );

   assign tag_rd = tag_type'(tag_rd_raw);

   // per-bucket count filter, bucket = low block bits
   fbcd_ram #(
      .WIDTH (COUNT_W),
      .DEPTH (ENTRIES)
   ) u_cnt_ram (
      .clock (clock),
      .we    (cnt_port.we),
      .waddr (cnt_port.waddr),
      .wdata (cnt_port.wdata),
      .raddr (cnt_port.raddr),
      .rdata (cnt_rd)
   );

   fbcd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .cfg        (cfg_ff),
      .tag_port   (tag_port),
      .tag_rd     (tag_rd),
      .cnt_port   (cnt_port),
      .cnt_rd     (cnt_rd),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

endmodule

// ===== tb/fbcd_checker.sv =====
// Checker for the FIFO block cache directory: mirrors tags, bucket counts and CSRs,
// predicts each result word and compares it with the one the block returns.
// Depends on fbcd_pkg (rtl/fbcd_pkg.sv).
`timescale 1ns / 1ps

module fbcd_checker
   import fbcd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 busy,
   input  req_type              req_word,
   input  logic                 rsp_strobe,
   input  rsp_type              rsp_word,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata,
   output int                   fail_count,
   output int                   words_pending,
   output int                   lookup_hits
);

   logic [BLK_W-1:0]   tag_blk    [ENTRIES];
   logic [DEV_W-1:0]   tag_dev    [ENTRIES];
   logic [COUNT_W-1:0] bucket_cnt [ENTRIES];
   int                 next_slot;
   logic               cache_off;
   logic [SIZE_W-1:0]  cache_sz;
   logic [DEV_W-1:0]   ram_dev;
   rsp_type            rsp_due [$];

   initial begin
      fail_count    = 0;
      words_pending = 0;
      lookup_hits   = 0;
   end

   task automatic log_mismatch(input string msg);
      $display("[%0t] directory mismatch: %s", $realtime, msg);
      fail_count++;
   endtask

   function automatic int slots_live();
      if (cache_off) return 0;
      return (cache_sz > ENTRIES) ? ENTRIES : int'(cache_sz);
   endfunction

   function automatic void count_down(logic [BLK_W-1:0] blk);
      if (bucket_cnt[blk[IDX_W-1:0]] != '0)
         bucket_cnt[blk[IDX_W-1:0]] = bucket_cnt[blk[IDX_W-1:0]] - 1'b1;
   endfunction

   function automatic void count_up(logic [BLK_W-1:0] blk);
      if (bucket_cnt[blk[IDX_W-1:0]] != COUNT_MAX)
         bucket_cnt[blk[IDX_W-1:0]] = bucket_cnt[blk[IDX_W-1:0]] + 1'b1;
   endfunction

   // Applies one request word to the mirrored directory, returns the result word.
   function automatic rsp_type predict_directory(req_type w);
      rsp_type r;
      int      n;
      int      b;
      r = '0;
      case (w.op)
         OP_LOOKUP: begin
            if (w.device == ram_dev) cache_off = 1'b1;
            n = slots_live();
            if (n != 0 && !w.search_only && bucket_cnt[w.block_number[IDX_W-1:0]] != '0) begin
               b = (next_slot < n) ? next_slot : 0;
               // newest first: walk backward from the pointer
               for (int i = 0; i < n; i++) begin
                  b = ((b == 0) ? n : b) - 1;
                  if (tag_blk[b] == w.block_number && tag_dev[b] == w.device) begin
                     r.hit  = 1'b1;
                     r.slot = SLOT_W'(b);
                     break;
                  end
               end
            end
         end
         OP_INSERT: begin
            n = slots_live();
            if (n != 0) begin
               b = (next_slot < n) ? next_slot : 0;
               next_slot = (b + 1 >= n) ? 0 : b + 1;
               if (tag_dev[b] != NO_DEVICE) count_down(tag_blk[b]);
               tag_dev[b] = w.device;
               tag_blk[b] = w.block_number;
               count_up(w.block_number);
               r.slot = SLOT_W'(b);
            end
         end
         OP_INVAL: begin
            n = slots_live();
            for (b = 0; b < n; b++) begin
               if (tag_dev[b] == w.device) begin
                  tag_dev[b] = NO_DEVICE;
                  count_down(tag_blk[b]);
               end
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) begin
            tag_blk[i]    = '0;
            tag_dev[i]    = NO_DEVICE;
            bucket_cnt[i] = '0;
         end
         next_slot = 0;
         cache_off = 1'b0;
         cache_sz  = '0;
         ram_dev   = RAM_DEVICE_RESET;
         rsp_due.delete();
      end else begin
         // results first: a word accepted at this edge cannot be answered at it
         if (rsp_strobe) begin
            if (rsp_due.size() == 0) begin
               log_mismatch($sformatf("unexpected result word hit=%0b slot=%0d",
                                      rsp_word.hit, rsp_word.slot));
            end else begin
               want = rsp_due.pop_front();
               if (rsp_word.hit !== want.hit)
                  log_mismatch($sformatf("hit %0b, expected %0b", rsp_word.hit, want.hit));
               if (rsp_word.slot !== want.slot)
                  log_mismatch($sformatf("slot %0d, expected %0d", rsp_word.slot, want.slot));
               if (want.hit) lookup_hits++;
            end
         end
         if (csr_we) begin
            case (csr_index)
               CSR_CACHE_SIZE: cache_sz = csr_wdata[SIZE_W-1:0];
               CSR_RAM_DEVICE: ram_dev  = csr_wdata[DEV_W-1:0];
               default: ;
            endcase
         end
         if (start && !busy) rsp_due.push_back(predict_directory(req_word));
      end
      words_pending = rsp_due.size();
   end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top for the FIFO block cache directory: clock, reset, CSR settings,
// directed and random request words, watchdog and verdict.
// Depends on fbcd_pkg, fifo_block_cache_directory_top and fbcd_checker.
`timescale 1ns / 1ps

module tb_top;
   import fbcd_pkg::*;

   // op code the block must answer with an empty result
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int N_PHASES   = 11;
   // no accept and no result for this long means the block hung; an invalidate
   // over 1024 slots plus the clearing pass fit many times over
   localparam int STALL_LIMIT = 20000;
   // longest walk (invalidate of a full directory) with margin
   localparam int DRAIN_CYCLES = 2200;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   req_type              req_word = '0;
   logic                 rsp_strobe;
   rsp_type              rsp_word;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_wdata = '0;

   int fail_count;
   int words_pending;
   int lookup_hits;

   fifo_block_cache_directory_top uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   fbcd_checker chk (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_word      (req_word),
      .rsp_strobe    (rsp_strobe),
      .rsp_word      (rsp_word),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .words_pending (words_pending),
      .lookup_hits   (lookup_hits)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog: any accepted word, result or CSR write counts as progress.
   int stall_cycles = 0;
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || csr_we) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Phase table: cache size, RAM device and number of random words.
   // Sizes stay small mostly; 1024 and 2047 (acts as 1024) get few words since
   // every invalidate walks the whole directory. The last two phases point the
   // RAM device at a device in use, so the cache goes dark and stays dark.
   int          ph_size  [N_PHASES] = '{1, 2, 0, 7, 16, 33, 1024, 2047, 5, 8, 12};
   logic [15:0] ph_ram   [N_PHASES] = '{16'd256, 16'd256, 16'd256, 16'h0000, 16'h0000,
                                        16'h8001, 16'h7ffe, 16'h00ff, 16'h4c1d,
                                        16'hffff, 16'hffff};
   int          ph_words [N_PHASES] = '{55, 55, 10, 70, 90, 90, 35, 30, 60, 30, 25};

   logic [DEV_W-1:0] ram_dev_now = RAM_DEVICE_RESET;
   logic [DEV_W-1:0] dev_pool [4];
   tag_type          recent_tags [$];

   function automatic req_type make_word(logic [1:0] op, logic [DEV_W-1:0] dev,
                                         logic [BLK_W-1:0] blk, logic only);
      req_type w;
      w.op           = op;
      w.device       = dev;
      w.block_number = blk;
      w.search_only  = only;
      return w;
   endfunction

   // Random word, biased toward sequences that reach the search: inserts from a
   // small device pool, lookups that reuse recently inserted tags or collide
   // with them in the count filter, invalidates of pooled devices, some noise.
   function automatic req_type random_word(bit may_disable);
      req_type     w;
      tag_type     pick;
      logic [31:0] r;
      int          roll;
      roll           = $urandom_range(0, 99);
      r              = $urandom();
      w.op           = OP_LOOKUP;
      w.device       = dev_pool[$urandom_range(0, 3)];
      w.block_number = $urandom();
      w.search_only  = ($urandom_range(0, 9) == 0);
      if (recent_tags.size() != 0)
         pick = recent_tags[$urandom_range(0, recent_tags.size() - 1)];
      else
         pick = {w.device, w.block_number};
      if (roll < 38) begin
         w.op = OP_INSERT;
         // pile onto a bucket that is already counted
         if ($urandom_range(0, 3) == 0)
            w.block_number = {r[BLK_W-1:IDX_W], pick.block[IDX_W-1:0]};
         recent_tags.push_back({w.device, w.block_number});
         if (recent_tags.size() > 48) void'(recent_tags.pop_front());
      end else if (roll < 80) begin
         if ($urandom_range(0, 99) < 65) begin
            w.device       = pick.device;
            w.block_number = pick.block;
         end else if ($urandom_range(0, 1) == 0) begin
            // filter says maybe, search says no
            w.block_number = {r[BLK_W-1:IDX_W], pick.block[IDX_W-1:0]};
         end
      end else if (roll < 92) begin
         w.op = OP_INVAL;
         if ($urandom_range(0, 1) == 0) w.device = pick.device;
      end else if (roll < 97) begin
         w.op     = OP_UNUSED;
         w.device = r[DEV_W-1:0];
      end else begin
         w.device = r[31:16];
      end
      // a lookup of the RAM device turns the cache off until reset: keep it for the end
      if (!may_disable && w.op == OP_LOOKUP && w.device == ram_dev_now)
         w.device = w.device ^ 16'h0001;
      return w;
   endfunction

   // Holds start high until the word is taken; start stays high on return.
   task automatic send_word(req_type w);
      start    <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (busy);
   endtask

   // Sender gap, with junk on the word lines while start is low.
   task automatic hold_off();
      logic [63:0] junk;
      int          gap;
      junk = {$urandom(), $urandom()};
      gap  = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 40) : $urandom_range(1, 3);
      start    <= 1'b0;
      req_word <= junk[$bits(req_type)-1:0];
      repeat (gap) @(posedge clock);
   endtask

   // Stop sending and wait until every result word is in and the block is idle.
   task automatic wait_idle();
      start <= 1'b0;
      do @(posedge clock); while (busy || words_pending != 0);
   endtask

   // Writes both CSRs on back-to-back cycles; only call while idle.
   task automatic set_config(int size, logic [DEV_W-1:0] ram_dev);
      csr_we    <= 1'b1;
      csr_index <= CSR_CACHE_SIZE;
      csr_wdata <= CSR_DAT_W'(size);
      @(posedge clock);
      csr_index <= CSR_RAM_DEVICE;
      csr_wdata <= ram_dev;
      @(posedge clock);
      csr_we <= 1'b0;
      ram_dev_now = ram_dev;
   endtask

   initial begin
      int      sent;
      int      rand_total;
      int      rand_done;
      int      idle_pct;
      req_type w;
      sent       = 0;
      rand_done  = 0;
      rand_total = 0;
      for (int p = 0; p < N_PHASES; p++) rand_total += ph_words[p];

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      // clearing pass after reset runs with busy high
      wait_idle();

      // --- directed part ---
      // Reset CSRs: cache size 0, so every op gives an empty result.
      send_word(make_word(OP_LOOKUP, 16'd1, 32'd0, 1'b0));
      send_word(make_word(OP_INSERT, 16'd1, 32'd0, 1'b0));
      send_word(make_word(OP_INVAL,  16'd1, 32'd0, 1'b0));
      sent += 3;
      wait_idle();

      set_config(4, RAM_DEVICE_RESET);
      send_word(make_word(OP_INSERT, 16'd1,    32'd0,         1'b0));  // slot 0
      send_word(make_word(OP_INSERT, 16'hffff, 32'hffff_ffff, 1'b0));  // slot 1
      send_word(make_word(OP_INSERT, NO_DEVICE, 32'h400,      1'b0));  // device 0, bucket 0
      send_word(make_word(OP_LOOKUP, 16'd1,    32'd0,         1'b0));  // hit, deepest
      send_word(make_word(OP_LOOKUP, 16'hffff, 32'hffff_ffff, 1'b1));  // search only: miss
      send_word(make_word(OP_LOOKUP, 16'hffff, 32'hffff_ffff, 1'b0));  // hit slot 1
      send_word(make_word(OP_LOOKUP, 16'd2,    32'h800,       1'b0));  // filter passes, no match
      send_word(make_word(OP_LOOKUP, 16'd1,    32'd7,         1'b0));  // empty bucket
      send_word(make_word(OP_UNUSED, 16'hffff, 32'hffff_ffff, 1'b1));  // unused op
      sent += 9;
      wait_idle();

      // shrink below the pointer (at 3): pointer acts as 0
      set_config(2, RAM_DEVICE_RESET);
      send_word(make_word(OP_LOOKUP, 16'd1,     32'd0, 1'b0));
      send_word(make_word(OP_INSERT, 16'd5,     32'd9, 1'b0));  // evicts device 1, block 0
      send_word(make_word(OP_INVAL,  NO_DEVICE, 32'd0, 1'b0));  // device-0 slot is out of range
      sent += 3;
      wait_idle();

      // grow back: invalidate of device 0 walks two device-0 slots, count saturates at 0
      set_config(4, RAM_DEVICE_RESET);
      send_word(make_word(OP_INVAL,  NO_DEVICE, 32'd0,         1'b0));
      send_word(make_word(OP_INVAL,  16'hffff,  32'd0,         1'b0));
      send_word(make_word(OP_LOOKUP, 16'hffff,  32'hffff_ffff, 1'b0));  // bucket now empty
      for (int i = 0; i < 4; i++)  // wraps the pointer
         send_word(make_word(OP_INSERT, NO_DEVICE, 32'd3 + i, 1'b0));
      sent += 7;
      wait_idle();

      // --- random part ---
      for (int p = 0; p < N_PHASES; p++) begin
         wait_idle();
         set_config(ph_size[p], ph_ram[p]);
         dev_pool[0] = DEV_W'($urandom_range(1, 7));
         dev_pool[1] = DEV_W'($urandom_range(0, 65535));
         dev_pool[2] = (p >= 9) ? 16'hffff : DEV_W'($urandom_range(0, 65535));
         dev_pool[3] = (p % 2 == 1) ? NO_DEVICE : DEV_W'($urandom_range(0, 65535));
         for (int i = 0; i < ph_words[p]; i++) begin
            // sender idles 28 %, then 61 %, then not at all
            if (rand_done < rand_total / 3)
               idle_pct = 28;
            else if (rand_done < 2 * rand_total / 3)
               idle_pct = 61;
            else
               idle_pct = 0;
            w = random_word(p >= 9);
            // make sure the RAM device lookup happens once the end is near
            if (p == 9 && i == 12) w = make_word(OP_LOOKUP, ram_dev_now, $urandom(), 1'b0);
            send_word(w);
            sent++;
            rand_done++;
            if ($urandom_range(0, 49) == 0)
               wait_idle();
            else if ($urandom_range(0, 99) < idle_pct)
               hold_off();
         end
      end

      wait_idle();
      // any late or stray result word would show up here
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run covered %0d request words over %0d CSR settings (cache size 0..2047,",
               sent, N_PHASES + 4);
      $display("RAM device 0..65535, cache shut off at the end); %0d lookups hit", lookup_hits);
      if (fail_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/fbcd_pkg.sv
rtl/fbcd_ram.sv
rtl/fbcd_ctrl.sv
rtl/fifo_block_cache_directory_top.sv
tb/fbcd_checker.sv
tb/tb_top.sv
